>>> hw/rtl/psf_pkg.sv
// ----------------------------------------------------------------------------
// psf_pkg: shared definitions for the printf-style formatter
// Sizes, character codes and the command and status types that join the
// controller to the datapath.
// ----------------------------------------------------------------------------
package psf_pkg;

   // Argument width on the port and width of the value that is formatted.
   localparam int ARG_BITS   = 32;
   localparam int VALUE_BITS = 32;
   localparam int WIDE_BITS  = VALUE_BITS + ARG_BITS;

   // Binary to decimal conversion takes two magnitude bits per cycle.
   localparam int PAD_BITS   = VALUE_BITS + (VALUE_BITS % 2);
   localparam int CONV_STEPS = PAD_BITS / 2;
   localparam int STEP_BITS  = $clog2(CONV_STEPS);

   // Digit counts: decimal is floor(bits * log10(2)) + 1.
   localparam int DEC_DIGITS     = (VALUE_BITS * 30103) / 100000 + 1;
   localparam int OCT_DIGITS     = (VALUE_BITS + 2) / 3;
   localparam int NUM_DIGITS     = (DEC_DIGITS > OCT_DIGITS) ? DEC_DIGITS : OCT_DIGITS;
   localparam int POS_BITS       = $clog2(NUM_DIGITS);
   localparam int DIGIT_VEC_BITS = NUM_DIGITS * 4;

   // Character codes.
   localparam logic [7:0] CH_NUL     = 8'h00;
   localparam logic [7:0] CH_PERCENT = 8'h25;
   localparam logic [7:0] CH_MINUS   = 8'h2D;
   localparam logic [7:0] CH_LOWER_C = 8'h63;
   localparam logic [7:0] CH_LOWER_D = 8'h64;
   localparam logic [7:0] CH_LOWER_U = 8'h75;
   localparam logic [7:0] CH_LOWER_X = 8'h78;
   localparam logic [7:0] CH_LOWER_O = 8'h6F;

   localparam logic [7:0] HEX_CHARS [16] = '{
      8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
      8'h38, 8'h39, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66
   };

   typedef enum logic [1:0] {
      RADIX_DEC_S,
      RADIX_DEC_U,
      RADIX_HEX,
      RADIX_OCT
   } radix_type;

   typedef enum logic [2:0] {
      SRC_BYTE,
      SRC_ARG,
      SRC_PERCENT,
      SRC_MINUS,
      SRC_DIGIT
   } char_src_type;

   typedef struct packed {
      logic         load;
      radix_type    radix;
      logic         conv_step;
      logic         find_lead;
      logic         pos_dec;
      logic         put;
      char_src_type src;
      logic         last;
   } dp_cmd_type;

   typedef struct packed {
      logic out_free;
      logic negative;
      logic pos_zero;
   } dp_status_type;

endpackage

>>> hw/rtl/psf_datapath.sv
// ----------------------------------------------------------------------------
// psf_datapath: digit datapath of the printf-style formatter
// Holds the magnitude, the digit buffer, the digit pointer and the output
// register, and carries out the commands of the controller.
// ----------------------------------------------------------------------------
module psf_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [7:0]                    req_format_byte,
   input  logic [psf_pkg::ARG_BITS-1:0]  req_argument_word,
   input  psf_pkg::dp_cmd_type           cmd,
   output psf_pkg::dp_status_type        status,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [7:0]                    rsp_out_char,
   output logic                          rsp_last_of_run
);
   import psf_pkg::*;

   logic [PAD_BITS-1:0]       mag_ff, mag_in;
   logic [DIGIT_VEC_BITS-1:0] digit_ff, digit_in;
   logic [POS_BITS-1:0]       pos_ff, pos_in;
   logic                      neg_ff, neg_in;
   logic                      out_valid_ff, out_valid_in;
   logic [7:0]                out_char_ff, out_char_in;
   logic                      out_last_ff, out_last_in;

   logic [WIDE_BITS-1:0]      arg_wide;
   logic [VALUE_BITS-1:0]     arg_val;
   logic [VALUE_BITS-1:0]     arg_abs;
   logic                      arg_neg;
   logic [DIGIT_VEC_BITS-1:0] arg_digits;
   logic [DIGIT_VEC_BITS-1:0] load_digits;
   logic [POS_BITS-1:0]       lead_pos;
   logic [3:0]                cur_digit;
   logic                      out_free;

   // One double-dabble step: adjust every BCD digit, then shift one bit in.
   function automatic logic [DIGIT_VEC_BITS-1:0] dd_shift(
      input logic [DIGIT_VEC_BITS-1:0] d,
      input logic                      b
   );
      logic [DIGIT_VEC_BITS-1:0] a;
      a = d;
      for (int i = 0; i < NUM_DIGITS; i++) begin
         if (a[4*i +: 4] >= 4'd5) begin
            a[4*i +: 4] = a[4*i +: 4] + 4'd3;
         end
      end
      return {a[DIGIT_VEC_BITS-2:0], b};
   endfunction

   assign arg_wide = WIDE_BITS'(req_argument_word);
   assign arg_val  = arg_wide[VALUE_BITS-1:0];
   assign arg_neg  = (cmd.radix == RADIX_DEC_S) && arg_val[VALUE_BITS-1];
   assign arg_abs  = arg_neg ? (~arg_val + VALUE_BITS'(1)) : arg_val;
   assign arg_digits = DIGIT_VEC_BITS'(arg_val);

   always_comb begin
      load_digits = '0;
      case (cmd.radix)
         RADIX_HEX: begin
            load_digits = arg_digits;
         end
         RADIX_OCT: begin
            for (int i = 0; i < NUM_DIGITS; i++) begin
               load_digits[4*i +: 4] = {1'b0, arg_digits[3*i +: 3]};
            end
         end
         default: begin
            load_digits = '0;
         end
      endcase
   end

   // Highest nonzero digit; a value of zero still prints digit zero.
   always_comb begin
      lead_pos = '0;
      for (int i = 0; i < NUM_DIGITS; i++) begin
         if (digit_ff[4*i +: 4] != 4'd0) begin
            lead_pos = POS_BITS'(i);
         end
      end
   end

   assign cur_digit = digit_ff[{pos_ff, 2'b00} +: 4];
   assign out_free  = !out_valid_ff || !rsp_stall;

   always_comb begin
      mag_in   = mag_ff;
      digit_in = digit_ff;
      neg_in   = neg_ff;
      if (cmd.load) begin
         mag_in   = PAD_BITS'(arg_abs);
         digit_in = load_digits;
         neg_in   = arg_neg;
      end else if (cmd.conv_step) begin
         mag_in   = mag_ff << 2;
         digit_in = dd_shift(dd_shift(digit_ff, mag_ff[PAD_BITS-1]), mag_ff[PAD_BITS-2]);
      end

      pos_in = pos_ff;
      if (cmd.find_lead) begin
         pos_in = lead_pos;
      end else if (cmd.pos_dec) begin
         pos_in = pos_ff - POS_BITS'(1);
      end

      out_valid_in = out_valid_ff;
      out_char_in  = out_char_ff;
      out_last_in  = out_last_ff;
      if (cmd.put) begin
         out_valid_in = 1'b1;
         out_last_in  = cmd.last;
         case (cmd.src)
            SRC_BYTE:    out_char_in = req_format_byte;
            SRC_ARG:     out_char_in = req_argument_word[7:0];
            SRC_PERCENT: out_char_in = CH_PERCENT;
            SRC_MINUS:   out_char_in = CH_MINUS;
            SRC_DIGIT:   out_char_in = HEX_CHARS[cur_digit];
            default:     out_char_in = CH_NUL;
         endcase
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      mag_ff      <= mag_in;
      digit_ff    <= digit_in;
      neg_ff      <= neg_in;
      pos_ff      <= pos_in;
      out_char_ff <= out_char_in;
      out_last_ff <= out_last_in;
   end

   assign status.out_free = out_free;
   assign status.negative = neg_ff;
   assign status.pos_zero = (pos_ff == '0);

   assign rsp_valid       = out_valid_ff;
   assign rsp_out_char    = out_char_ff;
   assign rsp_last_of_run = out_last_ff;

endmodule

>>> hw/rtl/psf_ctrl.sv
// ----------------------------------------------------------------------------
// psf_ctrl: controller of the printf-style formatter
// Decodes format bytes, keeps the pending percent flag and sequences the
// conversion, leading digit search and character output.
// ----------------------------------------------------------------------------
module psf_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [7:0]             req_format_byte,
   input  psf_pkg::dp_status_type status,
   output psf_pkg::dp_cmd_type    cmd
);
   import psf_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONV,
      ST_LEAD,
      ST_SIGN,
      ST_DIGIT
   } ctrl_state_type;

   ctrl_state_type       state_ff, state_in;
   logic                 pending_ff, pending_in;
   logic [STEP_BITS-1:0] step_ff, step_in;
   logic                 accept;

   assign req_stall = !((state_ff == ST_IDLE) && status.out_free);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in   = state_ff;
      pending_in = pending_ff;
      step_in    = step_ff;
      cmd        = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (!pending_ff) begin
                  if (req_format_byte == CH_PERCENT) begin
                     pending_in = 1'b1;
                  end else if (req_format_byte != CH_NUL) begin
                     cmd.put  = 1'b1;
                     cmd.src  = SRC_BYTE;
                     cmd.last = 1'b1;
                  end
               end else begin
                  pending_in = 1'b0;
                  step_in    = STEP_BITS'(CONV_STEPS - 1);
                  case (req_format_byte)
                     CH_LOWER_C: begin
                        cmd.put  = 1'b1;
                        cmd.src  = SRC_ARG;
                        cmd.last = 1'b1;
                     end
                     CH_PERCENT: begin
                        cmd.put  = 1'b1;
                        cmd.src  = SRC_PERCENT;
                        cmd.last = 1'b1;
                     end
                     CH_LOWER_D: begin
                        cmd.load  = 1'b1;
                        cmd.radix = RADIX_DEC_S;
                        state_in  = ST_CONV;
                     end
                     CH_LOWER_U: begin
                        cmd.load  = 1'b1;
                        cmd.radix = RADIX_DEC_U;
                        state_in  = ST_CONV;
                     end
                     CH_LOWER_X: begin
                        cmd.load  = 1'b1;
                        cmd.radix = RADIX_HEX;
                        state_in  = ST_LEAD;
                     end
                     CH_LOWER_O: begin
                        cmd.load  = 1'b1;
                        cmd.radix = RADIX_OCT;
                        state_in  = ST_LEAD;
                     end
                     default: begin
                        // Unknown letter or terminator: nothing is printed.
                     end
                  endcase
               end
            end
         end
         ST_CONV: begin
            cmd.conv_step = 1'b1;
            step_in       = step_ff - STEP_BITS'(1);
            if (step_ff == '0) begin
               state_in = ST_LEAD;
            end
         end
         ST_LEAD: begin
            cmd.find_lead = 1'b1;
            state_in      = status.negative ? ST_SIGN : ST_DIGIT;
         end
         ST_SIGN: begin
            if (status.out_free) begin
               cmd.put  = 1'b1;
               cmd.src  = SRC_MINUS;
               cmd.last = 1'b0;
               state_in = ST_DIGIT;
            end
         end
         ST_DIGIT: begin
            if (status.out_free) begin
               cmd.put     = 1'b1;
               cmd.src     = SRC_DIGIT;
               cmd.last    = status.pos_zero;
               cmd.pos_dec = 1'b1;
               if (status.pos_zero) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         pending_ff <= 1'b0;
         step_ff    <= '0;
      end else begin
         state_ff   <= state_in;
         pending_ff <= pending_in;
         step_ff    <= step_in;
      end
   end

endmodule

>>> hw/rtl/printf_style_formatter.sv
// ----------------------------------------------------------------------------
// printf_style_formatter: byte-serial integer formatter
// Echoes format bytes and expands %c, %d, %u, %x, %o and %% conversions
// into ASCII characters, most significant digit first.
// ----------------------------------------------------------------------------
//
//   Channel   Direction   Beat contents
//   req_      in          format_byte, argument_word
//   rsp_      out         out_char, last_of_run (set on the final character)
//
// An ordinary byte, %c or %% produces one beat. A %x or %o loads the
// argument, finds the leading digit and then puts out one digit per beat.
// A %d or %u first converts the magnitude from binary to BCD, two bits per
// cycle, and a negative %d then puts out a minus sign before the digits.
// Reset is synchronous and clears the controller state, the pending
// percent flag and the output valid flag. A stall on rsp_ holds the current
// beat and pauses digit output; req_stall stays high while a conversion runs.
//
module printf_style_formatter (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [7:0]                    req_format_byte,
   input  logic [psf_pkg::ARG_BITS-1:0]  req_argument_word,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [7:0]                    rsp_out_char,
   output logic                          rsp_last_of_run
);
   import psf_pkg::*;

   // Commands from the controller and status back from the datapath.
   dp_cmd_type    cmd;
   dp_status_type status;

   // The controller decodes each accepted byte and sequences the work.
   psf_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_format_byte (req_format_byte),
      .status          (status),
      .cmd             (cmd)
   );

   // The datapath holds the digits and the output register that drives rsp_.
   psf_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .req_format_byte   (req_format_byte),
      .req_argument_word (req_argument_word),
      .cmd               (cmd),
      .status            (status),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_char      (rsp_out_char),
      .rsp_last_of_run   (rsp_last_of_run)
   );

endmodule
